FILE: hdl/base64_stream_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// base64 stream encoder assertion macros
// shared assertion forms for the encoder modules
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64_STREAM_ENCODER_TOP_DEFINES_SVH

// checked only while out of reset
`define B64SE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("b64se assertion failed");

// checked on every rising edge, reset included
`define B64SE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("b64se assertion failed");

`endif

FILE: hdl/b64se_pkg.sv
// ----------------------------------------------------------------------------
// b64se_pkg
// types, codes and the alphabet lookup of the base64 stream encoder
// ----------------------------------------------------------------------------
package b64se_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned CharW = 7;
  localparam int unsigned MaxChars = 4;

  // position of the next byte within its three-byte group
  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseThird  = 2'd2;

  localparam logic [CharW-1:0] PadChar    = 7'h3D;
  localparam logic [CharW-1:0] AsciiUpper = 7'h41;
  localparam logic [CharW-1:0] AsciiLower = 7'h61;
  localparam logic [CharW-1:0] AsciiDigit = 7'h30;
  localparam logic [CharW-1:0] AsciiPlus  = 7'h2B;
  localparam logic [CharW-1:0] AsciiSlash = 7'h2F;

  // one classified byte: up to four characters for the back end
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [1:0]                     last_idx;
    logic                           eom;
  } job_t;

  function automatic logic [CharW-1:0] sym(input logic [5:0] six);
    logic [CharW-1:0] s;
    s = {1'b0, six};
    if (six < 6'd26) begin
      return AsciiUpper + s;
    end else if (six < 6'd52) begin
      return AsciiLower + s - 7'd26;
    end else if (six < 6'd62) begin
      return AsciiDigit + s - 7'd52;
    end else if (six == 6'd62) begin
      return AsciiPlus;
    end
    return AsciiSlash;
  endfunction

endpackage

FILE: hdl/b64se_front.sv
// ----------------------------------------------------------------------------
// b64se_front
// accepts bytes, tracks the group phase and builds the character words
// ----------------------------------------------------------------------------
module b64se_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_message_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output b64se_pkg::job_t  q_job_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       accept;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  always_comb begin
    q_job_o.chars    = {b64se_pkg::MaxChars{b64se_pkg::PadChar}};
    q_job_o.eom      = end_of_message_i;
    q_job_o.last_idx = 2'd0;
    phase_d          = b64se_pkg::PhaseFirst;
    left_d           = 4'd0;
    unique case (phase_q)
      b64se_pkg::PhaseSecond: begin
        q_job_o.chars[0] = b64se_pkg::sym({left_q[1:0], data_byte_i[7:4]});
        if (end_of_message_i) begin
          q_job_o.chars[1] = b64se_pkg::sym({data_byte_i[3:0], 2'b00});
          q_job_o.last_idx = 2'd2;
        end else begin
          left_d  = data_byte_i[3:0];
          phase_d = b64se_pkg::PhaseThird;
        end
      end
      b64se_pkg::PhaseThird: begin
        q_job_o.chars[0] = b64se_pkg::sym({left_q, data_byte_i[7:6]});
        q_job_o.chars[1] = b64se_pkg::sym(data_byte_i[5:0]);
        q_job_o.last_idx = 2'd1;
      end
      // unused phase code behaves as the start of a group
      default: begin
        q_job_o.chars[0] = b64se_pkg::sym(data_byte_i[7:2]);
        if (end_of_message_i) begin
          q_job_o.chars[1] = b64se_pkg::sym({data_byte_i[1:0], 4'b0000});
          q_job_o.last_idx = 2'd3;
        end else begin
          left_d  = {2'b00, data_byte_i[1:0]};
          phase_d = b64se_pkg::PhaseSecond;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64se_pkg::PhaseFirst;
      left_q  <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

FILE: hdl/b64se_queue.sv
// ----------------------------------------------------------------------------
// b64se_queue
// short word queue between the front and back ends
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_top_defines.svh"

module b64se_queue #(
  parameter int unsigned Depth = b64se_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64se_pkg::job_t  push_job_i,
  input  logic             pop_i,
  output b64se_pkg::job_t  head_job_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64se_pkg::job_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign head_job_o = slots_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `B64SE_ASSERT_ALWAYS(a_count_in_range, clk_i, count_q <= CntW'(Depth))
  `B64SE_ASSERT(a_ptr_gap_matches_count, clk_i, rst_ni,
                (count_q == '0 || count_q == CntW'(Depth)) |-> wr_ptr_q == rd_ptr_q)

endmodule

FILE: hdl/b64se_back.sv
// ----------------------------------------------------------------------------
// b64se_back
// walks the characters of each queued word into the output register
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_top_defines.svh"

module b64se_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  b64se_pkg::job_t               head_job_i,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [b64se_pkg::CharW-1:0]   out_char_o,
  output logic                          last_char_o
);

  logic [1:0]                 idx_q;
  logic                       valid_q;
  logic [b64se_pkg::CharW-1:0] char_q;
  logic                       last_q;
  logic                       load, at_end;

  // output slot is free when empty or being taken this cycle
  assign load    = !q_empty_i && (!valid_q || pop_i);
  assign at_end  = (idx_q == head_job_i.last_idx);
  assign q_pop_o = load && at_end;

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_job_i.chars[idx_q];
      last_q <= head_job_i.eom && at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign empty_o     = !valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

  `B64SE_ASSERT(a_idx_idle_zero, clk_i, rst_ni, q_empty_i |-> idx_q == 2'd0)
  `B64SE_ASSERT(a_idx_within_word, clk_i, rst_ni,
                !q_empty_i |-> idx_q <= head_job_i.last_idx)
  `B64SE_ASSERT(a_last_ends_word, clk_i, rst_ni,
                (load && head_job_i.eom && at_end) |=> (idx_q == 2'd0 && last_q))

endmodule

FILE: hdl/base64_stream_encoder_top.sv
// a byte is queued in a slot, then each character is registered at the result ports
// throughput: one character per cycle while pop is high; one to four per byte,
//   four thirds on average over long messages, set by the single output register
// queue of QueueDepth words lets the byte side run ahead of the character side
// reset (rst_ni low, asynchronous): group phase and leftover bits cleared, queue and
//   output emptied
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// byte stream to padded base64 character stream
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
  parameter int unsigned QueueDepth = b64se_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  data_byte_i,
  input  logic                        end_of_message_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [b64se_pkg::CharW-1:0] out_char_o,
  output logic                        last_char_o
);

  b64se_pkg::job_t push_job, head_job;
  logic            q_push, q_pop, q_full, q_empty;

  assign full = q_full;

  b64se_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_job_o          (push_job)
  );

  b64se_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .head_job_o (head_job),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  b64se_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_job_i  (head_job),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64 stream encoder testbench
// bytes go in through the push side, and each one is encoded by a predictor
// that keeps its own group phase and leftover bits. characters popped from the
// block are checked, in order, against the queue of predicted characters.
// the run covers directed groups, random messages under several idle and stall
// mixes, and a long hold-off on the pop side that fills the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned ReportMax  = 10;

  typedef struct {
    logic [b64se_pkg::CharW-1:0] ch;
    logic                        last;
  } enc_char_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        push = 1'b0;
  logic                        full;
  logic [7:0]                  data_byte_i = 8'h00;
  logic                        end_of_message_i = 1'b0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [b64se_pkg::CharW-1:0] out_char_o;
  logic                        last_char_o;

  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t   pending_chars_q[$];
  logic [1:0]  enc_phase = b64se_pkg::PhaseFirst;
  logic [3:0]  enc_carry = 4'h0;
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  base64_stream_encoder_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .empty            (empty),
    .pop              (pop),
    .out_char_o       (out_char_o),
    .last_char_o      (last_char_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [b64se_pkg::CharW-1:0] b64_char(input logic [5:0] six);
    logic [7:0] c;
    c = b64_alphabet[six];
    return c[b64se_pkg::CharW-1:0];
  endfunction

  function automatic void expect_char(input logic [b64se_pkg::CharW-1:0] ch, input logic last);
    enc_char_t e;
    e.ch   = ch;
    e.last = last;
    pending_chars_q.push_back(e);
  endfunction

  // encode one accepted byte into the characters it finishes
  function automatic void encode_byte(input logic [7:0] b, input logic eom);
    case (enc_phase)
      b64se_pkg::PhaseSecond: begin
        expect_char(b64_char({enc_carry[1:0], b[7:4]}), 1'b0);
        if (eom) begin
          expect_char(b64_char({b[3:0], 2'b00}), 1'b0);
          expect_char(b64se_pkg::PadChar, 1'b1);
          enc_phase = b64se_pkg::PhaseFirst;
          enc_carry = 4'h0;
        end else begin
          enc_carry = b[3:0];
          enc_phase = b64se_pkg::PhaseThird;
        end
      end
      b64se_pkg::PhaseThird: begin
        expect_char(b64_char({enc_carry, b[7:6]}), 1'b0);
        expect_char(b64_char(b[5:0]), eom);
        enc_phase = b64se_pkg::PhaseFirst;
        enc_carry = 4'h0;
      end
      default: begin
        expect_char(b64_char(b[7:2]), 1'b0);
        if (eom) begin
          expect_char(b64_char({b[1:0], 4'h0}), 1'b0);
          expect_char(b64se_pkg::PadChar, 1'b0);
          expect_char(b64se_pkg::PadChar, 1'b1);
          enc_phase = b64se_pkg::PhaseFirst;
          enc_carry = 4'h0;
        end else begin
          enc_carry = {2'b00, b[1:0]};
          enc_phase = b64se_pkg::PhaseSecond;
        end
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what, input int unsigned want, input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= ReportMax) begin
      $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    end
  endtask

  // pop side: random stalls, plus a counted hold-off when asked
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles = hold_off_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_chars
    enc_char_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_chars_q.size() == 0) begin
        note_mismatch("unexpected word", 0, {last_char_o, out_char_o});
      end else begin
        e = pending_chars_q.pop_front();
        if (out_char_o !== e.ch) begin
          note_mismatch("out_char", e.ch, out_char_o);
        end
        if (last_char_o !== e.last) begin
          note_mismatch("last_char", e.last, last_char_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout: no word moved for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push             <= 1'b1;
    data_byte_i      <= b;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    encode_byte(b, eom);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_chars_q.size() != 0) @(posedge clk_i);
  endtask

  // short messages ending in each group position, alphabet corners and extremes
  task automatic test_directed_groups();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    wait_drained();
  endtask

  // random messages, mostly short, with some stray single bytes
  task automatic test_random_messages(input int unsigned n_bytes, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
    int unsigned sent;
    int unsigned len;
    sent          = 0;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    while (sent < n_bytes) begin
      if ($urandom_range(99) < 15) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = ($urandom_range(99) < 80) ? $urandom_range(9, 1) : $urandom_range(40, 10);
        send_message(len);
        sent += len;
      end
    end
    wait_drained();
  endtask

  // pop side holds off while bytes keep coming, so the block must stall its input
  task automatic test_output_backpressure();
    send_idle_pct   = 0;
    pop_stall_pct   = 0;
    hold_off_cycles = 300;
    send_message(24);
    send_message(16);
    wait_drained();
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_groups();
    test_random_messages(120, 0, 0);
    test_random_messages(100, 82, 0);
    test_random_messages(100, 0, 82);
    test_random_messages(120, 36, 36);
    test_output_backpressure();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_chars_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
